// ===== hw/rtl/tdfsm_pkg.sv =====
// Shared constants and types for the table-driven state machine engine.
package tdfsm_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int STATE_BITS_DEF = 16;

    localparam int CMD_W     = 2;
    localparam int INDEX_W   = 4;
    localparam int MASK_W    = 16;
    localparam int EVENT_W   = 8;
    localparam int ACTION_W  = 8;
    localparam int STATE_W   = 16;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EVENT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FORCE = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FINISH
    } t_fsm_state;

endpackage

// ===== hw/rtl/tdfsm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module tdfsm_ram
    import tdfsm_pkg::*;
#(
    parameter int WIDTH = 48,
    parameter int DEPTH = ENTRIES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/table_driven_fsm_engine_unit.sv =====
// Top level of the table-driven state machine engine: control, table scan and result register.
// Write, force and unused commands pass through exec and finish to the registered result; an event
// scans k entries (1 to ENTRIES) between them, one per cycle from the table RAM.
// The next beat is taken in idle even while the previous result beat waits,
// and a stalled output holds the engine in its last state.
// Reset clears the current state, the entry valid bits and the output valid.
module table_driven_fsm_engine_unit
    import tdfsm_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int STATE_BITS = STATE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [INDEX_W-1:0]  i_entry_index,
    input  logic [MASK_W-1:0]   i_entry_state_mask,
    input  logic [EVENT_W-1:0]  i_entry_event,
    input  logic [STATE_W-1:0]  i_entry_next_state,
    input  logic [ACTION_W-1:0] i_entry_action,
    input  logic [EVENT_W-1:0]  i_event_code,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_matched,
    output logic [ACTION_W-1:0] o_action,
    output logic [STATE_W-1:0]  o_state_now
);

    localparam int IW      = $clog2(ENTRIES);
    localparam int SB      = STATE_BITS;
    localparam int ENTRY_W = 2 * SB + EVENT_W + ACTION_W;
    localparam logic [IW-1:0]      LAST_IDX  = IW'(ENTRIES - 1);
    localparam logic [INDEX_W+8:0] ENTRIES_W = (INDEX_W + 9)'(ENTRIES);

    // Captured input beat
    logic [CMD_W-1:0]    r_cmd;
    logic [INDEX_W-1:0]  r_idx;
    logic [SB-1:0]       r_emask;
    logic [EVENT_W-1:0]  r_eevent;
    logic [SB-1:0]       r_enext;
    logic [ACTION_W-1:0] r_eaction;
    logic [EVENT_W-1:0]  r_ev;

    t_fsm_state          r_state, n_state;
    logic [SB-1:0]       r_cur, n_cur;
    logic [IW-1:0]       r_scan, n_scan;
    logic                r_hit, n_hit;
    logic [ACTION_W-1:0] r_act, n_act;
    logic [ENTRIES-1:0]  r_valid;
    logic                r_rd_vld;

    logic                r_o_valid;
    logic                r_o_matched;
    logic [ACTION_W-1:0] r_o_action;
    logic [STATE_W-1:0]  r_o_state;

    logic                in_acc;
    logic                out_free;
    logic                wr_en;
    logic                wr_ok;
    logic                load_out;
    logic [IW-1:0]       wr_addr;
    logic [ENTRY_W-1:0]  wr_data;
    logic [ENTRY_W-1:0]  rd_data;
    logic [SB-1:0]       rd_mask;
    logic [EVENT_W-1:0]  rd_event;
    logic [SB-1:0]       rd_next;
    logic [ACTION_W-1:0] rd_action;
    logic                scan_end;
    logic                scan_match;
    logic [IW+INDEX_W-1:0] idx_ext;
    logic [SB+MASK_W-1:0]  mask_ext;
    logic [SB+STATE_W-1:0] next_ext;
    logic [SB+STATE_W-1:0] cur_ext;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_o_valid || i_out_ready;

    // Inputs are 16 bits wide; the stored state width may be narrower or wider.
    assign mask_ext = {{SB{1'b0}}, i_entry_state_mask};
    assign next_ext = {{SB{1'b0}}, i_entry_next_state};
    assign cur_ext  = {{STATE_W{1'b0}}, r_cur};
    assign idx_ext  = {{IW{1'b0}}, r_idx};
    assign wr_addr  = idx_ext[IW-1:0];
    assign wr_ok    = {9'd0, r_idx} < ENTRIES_W;
    assign wr_data  = {r_emask, r_eevent, r_enext, r_eaction};

    tdfsm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (n_scan),
        .o_rd_data (rd_data)
    );

    // A slot never written reads as an empty mask, which ends the scan.
    assign rd_mask    = r_rd_vld ? rd_data[ENTRY_W-1 -: SB] : '0;
    assign rd_event   = rd_data[SB+EVENT_W+ACTION_W-1 -: EVENT_W];
    assign rd_next    = rd_data[SB+ACTION_W-1 -: SB];
    assign rd_action  = rd_data[ACTION_W-1:0];
    assign scan_end   = (rd_mask == '0);
    assign scan_match = ((rd_mask & r_cur) != '0) && (rd_event == r_ev);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = (r_cmd == CMD_EVENT) ? S_SCAN : S_FINISH;
            end
            S_SCAN: begin
                if (scan_end || scan_match || (r_scan == LAST_IDX)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs and datapath next values
    always_comb begin
        o_in_ready = 1'b0;
        wr_en      = 1'b0;
        load_out   = 1'b0;
        n_cur      = r_cur;
        n_scan     = r_scan;
        n_hit      = r_hit;
        n_act      = r_act;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_EXEC: begin
                n_hit  = 1'b0;
                n_act  = '0;
                n_scan = '0;
                if (r_cmd == CMD_WRITE) begin
                    wr_en = wr_ok;
                end else if (r_cmd == CMD_FORCE) begin
                    n_cur = r_enext;
                end
            end
            S_SCAN: begin
                if (!scan_end && scan_match) begin
                    n_hit = 1'b1;
                    n_act = rd_action;
                    if (rd_next != '0) begin
                        n_cur = rd_next;
                    end
                end else if (!scan_end && (r_scan != LAST_IDX)) begin
                    n_scan = r_scan + 1'b1;
                end
            end
            S_FINISH: begin
                load_out = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cur     <= '0;
            r_valid   <= '0;
            r_hit     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_hit   <= n_hit;
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan   <= n_scan;
        r_act    <= n_act;
        r_rd_vld <= r_valid[n_scan];
        if (in_acc) begin
            r_cmd     <= i_cmd;
            r_idx     <= i_entry_index;
            r_emask   <= mask_ext[SB-1:0];
            r_eevent  <= i_entry_event;
            r_enext   <= next_ext[SB-1:0];
            r_eaction <= i_entry_action;
            r_ev      <= i_event_code;
        end
        if (load_out) begin
            r_o_matched <= r_hit;
            r_o_action  <= r_act;
            r_o_state   <= cur_ext[STATE_W-1:0];
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_matched   = r_o_matched;
    assign o_action    = r_o_action;
    assign o_state_now = r_o_state;

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_EXEC))
        else $error("accepted beat did not start execution");

    a_hit_only_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FINISH) && r_hit) |-> (r_cmd == CMD_EVENT))
        else $error("match flagged for a non-event command");

    a_nomatch_no_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_matched) |-> (o_action == '0))
        else $error("action reported without a match");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> ((r_state == S_EXEC) && (r_cmd == CMD_WRITE)))
        else $error("table written outside a write command");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

// ===== dv/table_driven_fsm_engine_unit_test.sv =====
// Self-checking testbench for the table-driven state machine engine with a behavioral predictor.
module table_driven_fsm_engine_unit_test;
    import tdfsm_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    localparam int RANDOM_ITEMS  = 1200;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 2 * ENTRIES_DEF + 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int SEND_IDLE_PCT = 37;
    localparam int RECV_IDLE_PCT = 46;
    localparam int MAX_PRINTS    = 40;

    typedef struct {
        logic [CMD_W-1:0]    cmd;
        logic [INDEX_W-1:0]  index;
        logic [MASK_W-1:0]   mask;
        logic [EVENT_W-1:0]  entry_ev;
        logic [STATE_W-1:0]  next_state;
        logic [ACTION_W-1:0] act;
        logic [EVENT_W-1:0]  code;
    } t_fsm_beat;

    typedef struct {
        logic                matched;
        logic [ACTION_W-1:0] act;
        logic [STATE_W-1:0]  state_now;
    } t_fsm_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid         = 1'b0;
    logic                o_in_ready;
    logic [CMD_W-1:0]    i_cmd              = '0;
    logic [INDEX_W-1:0]  i_entry_index      = '0;
    logic [MASK_W-1:0]   i_entry_state_mask = '0;
    logic [EVENT_W-1:0]  i_entry_event      = '0;
    logic [STATE_W-1:0]  i_entry_next_state = '0;
    logic [ACTION_W-1:0] i_entry_action     = '0;
    logic [EVENT_W-1:0]  i_event_code       = '0;
    logic                o_out_valid;
    logic                i_out_ready        = 1'b0;
    logic                o_matched;
    logic [ACTION_W-1:0] o_action;
    logic [STATE_W-1:0]  o_state_now;

    // Predictor copy of the transition table and the current state.
    logic [MASK_W-1:0]   tbl_mask   [ENTRIES_DEF];
    logic [EVENT_W-1:0]  tbl_event  [ENTRIES_DEF];
    logic [STATE_W-1:0]  tbl_next   [ENTRIES_DEF];
    logic [ACTION_W-1:0] tbl_action [ENTRIES_DEF];
    logic [STATE_W-1:0]  fsm_state;

    t_fsm_beat   pending_beats[$];
    t_fsm_result expected_results[$];
    t_fsm_beat   on_bus;
    t_fsm_result want_res;

    int total_items  = 0;
    int accepted_cnt = 0;
    int results_cnt  = 0;
    int mismatch_cnt = 0;
    int cycle_cnt    = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int n_writes = 0, n_forces = 0, n_events = 0, n_hits = 0, n_unused = 0;

    table_driven_fsm_engine_unit DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_cmd              (i_cmd),
        .i_entry_index      (i_entry_index),
        .i_entry_state_mask (i_entry_state_mask),
        .i_entry_event      (i_entry_event),
        .i_entry_next_state (i_entry_next_state),
        .i_entry_action     (i_entry_action),
        .i_event_code       (i_event_code),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_matched          (o_matched),
        .o_action           (o_action),
        .o_state_now        (o_state_now)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Applies one accepted beat to the predictor state and returns the result it causes.
    function automatic t_fsm_result apply_transition(input t_fsm_beat b);
        t_fsm_result r;
        bit          done;
        r.matched = 1'b0;
        r.act     = '0;
        done      = 1'b0;
        case (b.cmd)
            CMD_WRITE: begin
                if (int'(b.index) < ENTRIES_DEF) begin
                    tbl_mask[b.index]   = b.mask;
                    tbl_event[b.index]  = b.entry_ev;
                    tbl_next[b.index]   = b.next_state;
                    tbl_action[b.index] = b.act;
                end
                n_writes++;
            end
            CMD_EVENT: begin
                n_events++;
                // A zero mask ends the table; a full table ends after the last slot.
                for (int i = 0; i < ENTRIES_DEF; i++) begin
                    if (!done) begin
                        if (tbl_mask[i] == '0) begin
                            done = 1'b1;
                        end else if ((tbl_mask[i] & fsm_state) != '0 &&
                                     tbl_event[i] == b.code) begin
                            if (tbl_next[i] != '0)
                                fsm_state = tbl_next[i];
                            r.matched = 1'b1;
                            r.act     = tbl_action[i];
                            done      = 1'b1;
                        end
                    end
                end
                if (r.matched)
                    n_hits++;
            end
            CMD_FORCE: begin
                fsm_state = b.next_state;
                n_forces++;
            end
            default: begin
                n_unused++;
            end
        endcase
        r.state_now = fsm_state;
        return r;
    endfunction

    function automatic t_fsm_beat mk_beat(input logic [CMD_W-1:0] cmd,
                                          input logic [INDEX_W-1:0] idx,
                                          input logic [MASK_W-1:0] mask,
                                          input logic [EVENT_W-1:0] entry_ev,
                                          input logic [STATE_W-1:0] next_state,
                                          input logic [ACTION_W-1:0] act,
                                          input logic [EVENT_W-1:0] code);
        t_fsm_beat b;
        b.cmd        = cmd;
        b.index      = idx;
        b.mask       = mask;
        b.entry_ev   = entry_ev;
        b.next_state = next_state;
        b.act        = act;
        b.code       = code;
        return b;
    endfunction

    function automatic t_fsm_beat noise_beat();
        return mk_beat(CMD_W'($urandom_range(0, 3)), INDEX_W'($urandom), MASK_W'($urandom),
                       EVENT_W'($urandom), STATE_W'($urandom), ACTION_W'($urandom),
                       EVENT_W'($urandom));
    endfunction

    function automatic int send_idle_pct();
        if (accepted_cnt < total_items / 3)
            return SEND_IDLE_PCT;
        else if (accepted_cnt < (2 * total_items) / 3)
            return RECV_IDLE_PCT;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (accepted_cnt < total_items / 3)
            return RECV_IDLE_PCT;
        else if (accepted_cnt < (2 * total_items) / 3)
            return SEND_IDLE_PCT;
        return 0;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_PRINTS)
            $display("mismatch at cycle %0d, result %0d: %s", cycle_cnt, results_cnt, msg);
    endtask

    // Input driver: predicts each beat as it is accepted, then offers the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(apply_transition(on_bus));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_beats.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
                    on_bus = pending_beats.pop_front();
                    i_cmd              <= on_bus.cmd;
                    i_entry_index      <= on_bus.index;
                    i_entry_state_mask <= on_bus.mask;
                    i_entry_event      <= on_bus.entry_ev;
                    i_entry_next_state <= on_bus.next_state;
                    i_entry_action     <= on_bus.act;
                    i_event_code       <= on_bus.code;
                    i_in_valid         <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // One long output stall late in the run, while the sender keeps offering beats.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && accepted_cnt >= (5 * total_items) / 6) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Output monitor.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result beat with no item outstanding");
                end else begin
                    want_res = expected_results.pop_front();
                    if (o_matched !== want_res.matched)
                        report_mismatch($sformatf("matched got %0b want %0b",
                                                  o_matched, want_res.matched));
                    if (o_action !== want_res.act)
                        report_mismatch($sformatf("action got %02h want %02h",
                                                  o_action, want_res.act));
                    if (o_state_now !== want_res.state_now)
                        report_mismatch($sformatf("state_now got %04h want %04h",
                                                  o_state_now, want_res.state_now));
                end
                results_cnt++;
            end
            i_out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct());
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_cnt, expected_results.size());
            $display("table_driven_fsm_engine_unit_test: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int                  made;
        int                  n_states;
        int                  n_codes;
        int                  k;
        int                  n_ev;
        int                  r;
        logic [STATE_W-1:0]  states [8];
        logic [EVENT_W-1:0]  codes  [6];
        t_fsm_beat           b;

        for (int i = 0; i < ENTRIES_DEF; i++) begin
            tbl_mask[i]   = '0;
            tbl_event[i]  = '0;
            tbl_next[i]   = '0;
            tbl_action[i] = '0;
        end
        fsm_state = '0;

        // Directed part: empty table, unused command, a full table scanned to its end,
        // next state zero, and a forced zero state that nothing can match.
        pending_beats.push_back(mk_beat(CMD_EVENT, '0, '0, '0, '0, '0, 8'h00));
        pending_beats.push_back(mk_beat(CMD_NONE, '1, '1, '1, '1, '1, '1));
        pending_beats.push_back(mk_beat(CMD_FORCE, '0, '0, '0, 16'hFFFF, '0, '0));
        pending_beats.push_back(mk_beat(CMD_EVENT, '0, '0, '0, '0, '0, 8'hFF));
        for (int i = 0; i < ENTRIES_DEF - 1; i++)
            pending_beats.push_back(mk_beat(CMD_WRITE, INDEX_W'(i), MASK_W'(1) << i,
                                            EVENT_W'(i), STATE_W'(i), ACTION_W'(i + 1),
                                            '0));
        pending_beats.push_back(mk_beat(CMD_WRITE, 4'hF, 16'h8000, 8'hFF, 16'hFFFF, 8'hFF,
                                        '0));
        pending_beats.push_back(mk_beat(CMD_FORCE, '0, '0, '0, 16'h8000, '0, '0));
        pending_beats.push_back(mk_beat(CMD_EVENT, '0, '0, '0, '0, '0, 8'hFF));
        pending_beats.push_back(mk_beat(CMD_FORCE, '0, '0, '0, 16'h0001, '0, '0));
        pending_beats.push_back(mk_beat(CMD_EVENT, '0, '0, '0, '0, '0, 8'h00));
        pending_beats.push_back(mk_beat(CMD_EVENT, '0, '0, '0, '0, '0, 8'h77));
        pending_beats.push_back(mk_beat(CMD_FORCE, '0, '0, '0, 16'h0000, '0, '0));
        pending_beats.push_back(mk_beat(CMD_EVENT, '0, '0, '0, '0, '0, 8'h00));

        // Random part: each episode loads a small machine over a few states and event
        // codes, forces a start state and walks it with events, mixed with noise beats.
        made = 0;
        while (made < RANDOM_ITEMS) begin
            n_states = $urandom_range(2, 8);
            for (int i = 0; i < n_states; i++) begin
                states[i] = STATE_W'(1) << $urandom_range(0, STATE_W - 1);
                if ($urandom_range(0, 4) == 0)
                    states[i] = states[i] | (STATE_W'(1) << $urandom_range(0, STATE_W - 1));
            end
            n_codes = $urandom_range(1, 6);
            for (int i = 0; i < n_codes; i++)
                codes[i] = EVENT_W'($urandom);
            k = $urandom_range(1, ENTRIES_DEF);
            for (int i = 0; i < k; i++) begin
                b = noise_beat();
                b.cmd      = CMD_WRITE;
                b.index    = INDEX_W'(i);
                b.mask     = ($urandom_range(0, 9) == 0) ? MASK_W'($urandom)
                                                         : states[$urandom_range(0, n_states - 1)];
                b.entry_ev = codes[$urandom_range(0, n_codes - 1)];
                b.next_state = ($urandom_range(0, 4) == 0) ? '0
                                                           : states[$urandom_range(0, n_states - 1)];
                pending_beats.push_back(b);
                made++;
            end
            if (k < ENTRIES_DEF && $urandom_range(0, 3) != 0) begin
                b = noise_beat();
                b.cmd   = CMD_WRITE;
                b.index = INDEX_W'(k);
                b.mask  = '0;
                pending_beats.push_back(b);
                made++;
            end
            b = noise_beat();
            b.cmd        = CMD_FORCE;
            b.next_state = states[$urandom_range(0, n_states - 1)];
            pending_beats.push_back(b);
            made++;
            n_ev = $urandom_range(5, 30);
            for (int j = 0; j < n_ev; j++) begin
                b = noise_beat();
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    b.cmd  = CMD_EVENT;
                    b.code = ($urandom_range(0, 9) == 0) ? EVENT_W'($urandom)
                                                         : codes[$urandom_range(0, n_codes - 1)];
                end else if (r < 88) begin
                    b.cmd        = CMD_FORCE;
                    b.next_state = states[$urandom_range(0, n_states - 1)];
                end else if (r < 94) begin
                    b.cmd      = CMD_WRITE;
                    b.mask     = states[$urandom_range(0, n_states - 1)];
                    b.entry_ev = codes[$urandom_range(0, n_codes - 1)];
                end
                pending_beats.push_back(b);
                if (b.cmd != CMD_NONE)
                    made++;
            end
        end
        total_items = pending_beats.size();

        while (accepted_cnt < total_items || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_results.size()));

        $display("covered %0d beats: %0d table writes, %0d forces, %0d unused commands",
                 total_items, n_writes, n_forces, n_unused);
        $display("%0d events (%0d matched), %0d mismatches", n_events, n_hits, mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("table_driven_fsm_engine_unit_test: PASS");
        end else begin
            $display("table_driven_fsm_engine_unit_test: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/tdfsm_pkg.sv
hw/rtl/tdfsm_ram.sv
hw/rtl/table_driven_fsm_engine_unit.sv
dv/table_driven_fsm_engine_unit_test.sv
